### design/fdtd_pkg.sv
// Shared types, constants and address helper for the FDTD field update block.
package fdtd_pkg;

    // Grid capacity along each axis.
    localparam int MAX_X = 8;
    localparam int MAX_Y = 8;
    localparam int MAX_Z = 8;

    localparam int CELLS      = MAX_X * MAX_Y * MAX_Z;
    localparam int DEPTH      = 3 * CELLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int X_W        = $clog2(MAX_X);
    localparam int Y_W        = $clog2(MAX_Y);
    localparam int Z_W        = $clog2(MAX_Z);
    localparam int XE_W       = $clog2(MAX_X + 1);
    localparam int DIM_W      = 8;
    localparam int DATA_W     = 32;
    localparam int NUM_STORES = 6;
    localparam int TGT_W      = 3;

    // Command codes.
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_VSWEEP = 3'd2;
    localparam logic [2:0] CMD_CSWEEP = 3'd3;

    // Store (target) codes.
    localparam logic [TGT_W-1:0] TGT_VOLT = 3'd0;
    localparam logic [TGT_W-1:0] TGT_CURR = 3'd1;
    localparam logic [TGT_W-1:0] TGT_VV   = 3'd2;
    localparam logic [TGT_W-1:0] TGT_VI   = 3'd3;
    localparam logic [TGT_W-1:0] TGT_II   = 3'd4;
    localparam logic [TGT_W-1:0] TGT_IV   = 3'd5;

    // Component codes, also used as axis codes.
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_CLIPPED  = 2'd2;

    // Job kinds handed from the front end to the engine.
    localparam logic [2:0] JOB_DONE   = 3'd0;
    localparam logic [2:0] JOB_WRITE  = 3'd1;
    localparam logic [2:0] JOB_READ   = 3'd2;
    localparam logic [2:0] JOB_VSWEEP = 3'd3;
    localparam logic [2:0] JOB_CSWEEP = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic [2:0]               target;
        logic [1:0]               component;
        logic [2:0]               cell_x;
        logic [2:0]               cell_y;
        logic [2:0]               cell_z;
        logic [3:0]               plane_count;
        logic signed [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic [1:0]               status;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] sx;
        logic [DIM_W-1:0] sy;
        logic [DIM_W-1:0] sz;
    } t_dims;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TGT_W-1:0]  target;
        logic [1:0]        comp;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [Z_W-1:0]    z;
        logic [XE_W-1:0]   x_end;
        logic [DATA_W-1:0] wdata;
        logic [1:0]        status;
    } t_job;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [1:0] c,
                                                    input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y,
                                                    input logic [Z_W-1:0] z);
        int a;
        a = int'(c) * CELLS + (int'(x) * MAX_Y + int'(y)) * MAX_Z + int'(z);
        return ADDR_W'(a);
    endfunction

endpackage

### design/fdtd_front.sv
// Front end: classifies incoming commands and queues them for the engine.
module fdtd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdtd_pkg::t_in_item i_item,
    input  logic              i_push,
    output logic              o_full,
    input  fdtd_pkg::t_dims   i_dims,
    input  logic              i_clearing,
    output fdtd_pkg::t_job    o_job,
    output logic              o_job_valid,
    input  logic              i_job_take
);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    fdtd_pkg::t_job                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]            r_wr_ptr;
    logic [Q_PTR_W-1:0]            r_rd_ptr;
    logic [Q_PTR_W:0]              r_count;
    fdtd_pkg::t_job                w_job;
    logic [fdtd_pkg::DIM_W-1:0]    w_limit;
    logic [fdtd_pkg::DIM_W-1:0]    w_x_end;
    logic [fdtd_pkg::DIM_W-1:0]    w_cx;
    logic                          w_in_range;
    logic                          w_accept;

    // Classify the command and clip sweep ranges against the grid in use.
    always_comb begin
        w_cx       = fdtd_pkg::DIM_W'(i_item.cell_x);
        w_in_range = (w_cx < i_dims.sx)
                  && (fdtd_pkg::DIM_W'(i_item.cell_y) < i_dims.sy)
                  && (fdtd_pkg::DIM_W'(i_item.cell_z) < i_dims.sz);
        w_limit    = (i_item.cmd == fdtd_pkg::CMD_VSWEEP) ? i_dims.sx : i_dims.sx - 1'b1;
        w_x_end    = w_cx + fdtd_pkg::DIM_W'(i_item.plane_count);
        w_job        = '0;
        w_job.target = i_item.target;
        w_job.comp   = i_item.component;
        w_job.x      = fdtd_pkg::X_W'(i_item.cell_x);
        w_job.y      = fdtd_pkg::Y_W'(i_item.cell_y);
        w_job.z      = fdtd_pkg::Z_W'(i_item.cell_z);
        w_job.wdata  = i_item.write_data;
        w_job.kind   = fdtd_pkg::JOB_DONE;
        w_job.status = fdtd_pkg::ST_OK;
        case (i_item.cmd)
            fdtd_pkg::CMD_WRITE, fdtd_pkg::CMD_READ: begin
                if (i_item.target > fdtd_pkg::TGT_IV || i_item.component > fdtd_pkg::COMP_Z
                        || !w_in_range) begin
                    w_job.status = fdtd_pkg::ST_BAD_ADDR;
                end else begin
                    w_job.kind = (i_item.cmd == fdtd_pkg::CMD_WRITE) ? fdtd_pkg::JOB_WRITE
                                                                      : fdtd_pkg::JOB_READ;
                end
            end
            fdtd_pkg::CMD_VSWEEP, fdtd_pkg::CMD_CSWEEP: begin
                if (w_x_end > w_limit) begin
                    w_x_end      = w_limit;
                    w_job.status = fdtd_pkg::ST_CLIPPED;
                end
                if (w_cx < w_x_end) begin
                    w_job.kind = (i_item.cmd == fdtd_pkg::CMD_VSWEEP) ? fdtd_pkg::JOB_VSWEEP
                                                                       : fdtd_pkg::JOB_CSWEEP;
                end
            end
            default: begin
                w_job.kind = fdtd_pkg::JOB_DONE;
            end
        endcase
        w_job.x_end = fdtd_pkg::XE_W'(w_x_end);
    end

    assign o_full      = (r_count == (Q_PTR_W + 1)'(Q_DEPTH)) || i_clearing;
    assign w_accept    = i_push && !o_full;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_accept) begin
                r_q[r_wr_ptr] <= w_job;
                r_wr_ptr      <= r_wr_ptr + 1'b1;
            end
            if (i_job_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (Q_PTR_W + 1)'(w_accept) - (Q_PTR_W + 1)'(i_job_take);
        end
    end

endmodule

### design/fdtd_engine.sv
// Back end: field stores, sweep sequencer and shared multiply-add datapath.
module fdtd_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fdtd_pkg::t_dims    i_dims,
    input  fdtd_pkg::t_job     i_job,
    input  logic               i_job_valid,
    output logic               o_job_take,
    output logic               o_clearing,
    output fdtd_pkg::t_out_item o_result,
    output logic               o_empty,
    input  logic               i_pop
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_RDATA = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_MUL0  = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_RND   = 4'd7;
    localparam logic [3:0] S_WB    = 4'd8;

    localparam int ACC_W  = fdtd_pkg::DATA_W + 3;
    localparam int PROD_W = 2 * fdtd_pkg::DATA_W;
    localparam int RND_W  = PROD_W - 30;

    typedef struct packed {
        logic [fdtd_pkg::ADDR_W-1:0] addr;
        logic                        neg;
        logic                        zero;
    } t_term;

    logic [3:0]                        r_state;
    logic [fdtd_pkg::ADDR_W-1:0]       r_clr_cnt;
    logic [2:0]                        r_kind;
    logic [fdtd_pkg::TGT_W-1:0]        r_tgt;
    logic [1:0]                        r_comp;
    logic [fdtd_pkg::X_W-1:0]          r_x;
    logic [fdtd_pkg::Y_W-1:0]          r_y;
    logic [fdtd_pkg::Z_W-1:0]          r_z;
    logic [fdtd_pkg::XE_W-1:0]         r_x_end;
    logic [fdtd_pkg::DATA_W-1:0]       r_wdata;
    logic [1:0]                        r_status;
    logic [2:0]                        r_k;
    logic                              r_tneg;
    logic                              r_tzero;
    logic signed [ACC_W-1:0]           r_curl;
    logic signed [fdtd_pkg::DATA_W-1:0] r_own;
    logic signed [fdtd_pkg::DATA_W-1:0] r_dec;
    logic signed [fdtd_pkg::DATA_W-1:0] r_cpl;
    logic signed [fdtd_pkg::DATA_W-1:0] r_curl_sat;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [RND_W-1:0]           r_p0;
    logic signed [RND_W-1:0]           r_p1;
    fdtd_pkg::t_out_item               r_res;
    logic                              r_res_valid;
    logic [fdtd_pkg::DATA_W-1:0]       r_rdata [fdtd_pkg::NUM_STORES];

    logic                              w_vsweep;
    logic [fdtd_pkg::TGT_W-1:0]        w_own_idx;
    logic [fdtd_pkg::TGT_W-1:0]        w_other_idx;
    logic [fdtd_pkg::TGT_W-1:0]        w_dec_idx;
    logic [fdtd_pkg::TGT_W-1:0]        w_cpl_idx;
    logic [fdtd_pkg::ADDR_W-1:0]       w_base_addr;
    t_term                             w_term;
    logic [fdtd_pkg::ADDR_W-1:0]       w_raddr [fdtd_pkg::NUM_STORES];
    logic [fdtd_pkg::NUM_STORES-1:0]   w_we;
    logic [fdtd_pkg::ADDR_W-1:0]       w_waddr;
    logic [fdtd_pkg::DATA_W-1:0]       w_wdata;
    logic signed [fdtd_pkg::DATA_W-1:0] w_mul_a;
    logic signed [fdtd_pkg::DATA_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]          w_prod;
    logic signed [ACC_W-1:0]           w_tval;
    logic signed [fdtd_pkg::DATA_W-1:0] w_new_val;
    logic [fdtd_pkg::DIM_W-1:0]        w_ylim;
    logic                              w_last_z;
    logic                              w_last_y;
    logic                              w_last_x;

    // Saturate a wide signed value to the 32-bit range.
    function automatic logic signed [fdtd_pkg::DATA_W-1:0] sat32(
            input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[fdtd_pkg::DATA_W-1:0];
        end else if (v < lo) begin
            return lo[fdtd_pkg::DATA_W-1:0];
        end
        return v[fdtd_pkg::DATA_W-1:0];
    endfunction

    // Q2.30 times Q16.16 back to Q16.16, rounding half up.
    function automatic logic signed [RND_W-1:0] round30(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) << 29);
        return t[PROD_W-1:30];
    endfunction

    // One of the four curl terms of a field component. Terms 0 and 2 are the
    // cell itself, terms 1 and 3 the neighbor along the other two axes.
    function automatic t_term term_of(input logic [1:0] c, input logic [1:0] k,
                                      input logic [fdtd_pkg::X_W-1:0] x,
                                      input logic [fdtd_pkg::Y_W-1:0] y,
                                      input logic [fdtd_pkg::Z_W-1:0] z,
                                      input logic volt,
                                      input logic [fdtd_pkg::DIM_W-1:0] sz);
        t_term                    t;
        logic [1:0]               ca;
        logic [1:0]               cb;
        logic [1:0]               csel;
        logic [1:0]               axis;
        logic                     shift;
        logic [fdtd_pkg::X_W-1:0] tx;
        logic [fdtd_pkg::Y_W-1:0] ty;
        logic [fdtd_pkg::Z_W-1:0] tz;
        case (c)
            fdtd_pkg::COMP_X: begin
                ca = fdtd_pkg::COMP_Z;
                cb = fdtd_pkg::COMP_Y;
            end
            fdtd_pkg::COMP_Y: begin
                ca = fdtd_pkg::COMP_X;
                cb = fdtd_pkg::COMP_Z;
            end
            default: begin
                ca = fdtd_pkg::COMP_Y;
                cb = fdtd_pkg::COMP_X;
            end
        endcase
        case (k)
            2'd0: begin
                csel = ca; axis = cb; shift = 1'b0; t.neg = 1'b0;
            end
            2'd1: begin
                csel = ca; axis = cb; shift = 1'b1; t.neg = 1'b1;
            end
            2'd2: begin
                csel = cb; axis = ca; shift = 1'b0; t.neg = 1'b1;
            end
            default: begin
                csel = cb; axis = ca; shift = 1'b1; t.neg = 1'b0;
            end
        endcase
        tx     = x;
        ty     = y;
        tz     = z;
        t.zero = 1'b0;
        if (shift) begin
            case (axis)
                fdtd_pkg::COMP_X: begin
                    if (volt) begin
                        tx = (x == '0) ? x : x - 1'b1;
                    end else begin
                        tx = x + 1'b1;
                    end
                end
                fdtd_pkg::COMP_Y: begin
                    if (volt) begin
                        ty = (y == '0) ? y : y - 1'b1;
                    end else begin
                        ty = y + 1'b1;
                    end
                end
                default: begin
                    if (volt) begin
                        if (z == '0) begin
                            t.zero = 1'b1;
                        end else begin
                            tz = z - 1'b1;
                        end
                    end else if (fdtd_pkg::DIM_W'(z) + 1'b1 >= sz) begin
                        t.zero = 1'b1;
                    end else begin
                        tz = z + 1'b1;
                    end
                end
            endcase
        end
        t.addr = fdtd_pkg::cell_addr(csel, tx, ty, tz);
        return t;
    endfunction

    assign w_vsweep    = (r_kind == fdtd_pkg::JOB_VSWEEP);
    assign w_own_idx   = w_vsweep ? fdtd_pkg::TGT_VOLT : fdtd_pkg::TGT_CURR;
    assign w_other_idx = w_vsweep ? fdtd_pkg::TGT_CURR : fdtd_pkg::TGT_VOLT;
    assign w_dec_idx   = w_vsweep ? fdtd_pkg::TGT_VV : fdtd_pkg::TGT_II;
    assign w_cpl_idx   = w_vsweep ? fdtd_pkg::TGT_VI : fdtd_pkg::TGT_IV;
    assign w_base_addr = fdtd_pkg::cell_addr(r_comp, r_x, r_y, r_z);
    assign w_term      = term_of(r_comp, r_k[1:0], r_x, r_y, r_z, w_vsweep, i_dims.sz);

    // Read addresses: the neighbor field follows the term walk, all others sit
    // on the word being updated or accessed.
    always_comb begin
        for (int i = 0; i < fdtd_pkg::NUM_STORES; i++) begin
            if (r_state == S_RD && w_other_idx == fdtd_pkg::TGT_W'(i)) begin
                w_raddr[i] = w_term.addr;
            end else begin
                w_raddr[i] = w_base_addr;
            end
        end
    end

    assign w_tval    = r_tzero ? '0 : ACC_W'(signed'(r_rdata[w_other_idx]));
    assign w_mul_a   = (r_state == S_MUL0) ? r_dec : r_cpl;
    assign w_mul_b   = (r_state == S_MUL0) ? r_own : r_curl_sat;
    assign w_prod    = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_new_val = sat32(ACC_W'(r_p0) + ACC_W'(r_p1));

    // Write port shared by all stores; only one store is written per cycle,
    // except while the voltage and current stores are being cleared.
    always_comb begin
        w_waddr = w_base_addr;
        w_wdata = w_new_val;
        for (int i = 0; i < fdtd_pkg::NUM_STORES; i++) begin
            case (r_state)
                S_CLEAR: begin
                    w_we[i] = (fdtd_pkg::TGT_W'(i) == fdtd_pkg::TGT_VOLT)
                           || (fdtd_pkg::TGT_W'(i) == fdtd_pkg::TGT_CURR);
                end
                S_EXEC: begin
                    w_we[i] = (r_kind == fdtd_pkg::JOB_WRITE) && (r_tgt == fdtd_pkg::TGT_W'(i));
                end
                S_WB: begin
                    w_we[i] = (w_own_idx == fdtd_pkg::TGT_W'(i));
                end
                default: begin
                    w_we[i] = 1'b0;
                end
            endcase
        end
        if (r_state == S_CLEAR) begin
            w_waddr = r_clr_cnt;
            w_wdata = '0;
        end else if (r_state == S_EXEC) begin
            w_wdata = r_wdata;
        end
    end

    genvar g;
    generate
        for (g = 0; g < fdtd_pkg::NUM_STORES; g++) begin : g_store
            logic [fdtd_pkg::DATA_W-1:0] r_mem [fdtd_pkg::DEPTH];
            always_ff @(posedge i_clk) begin
                if (w_we[g]) begin
                    r_mem[w_waddr] <= w_wdata;
                end
                r_rdata[g] <= r_mem[w_raddr[g]];
            end
        end
    endgenerate

    assign w_ylim   = w_vsweep ? i_dims.sy : i_dims.sy - 1'b1;
    assign w_last_z = (fdtd_pkg::DIM_W'(r_z) + 1'b1 >= i_dims.sz);
    assign w_last_y = (fdtd_pkg::DIM_W'(r_y) + 1'b1 >= w_ylim);
    assign w_last_x = (fdtd_pkg::XE_W'(r_x) + 1'b1 >= r_x_end);

    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !r_res_valid;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_result   = r_res;
    assign o_empty    = !r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == fdtd_pkg::ADDR_W'(fdtd_pkg::DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_job_take) begin
                        r_kind   <= i_job.kind;
                        r_tgt    <= i_job.target;
                        r_x      <= i_job.x;
                        r_x_end  <= i_job.x_end;
                        r_wdata  <= i_job.wdata;
                        r_status <= i_job.status;
                        if (i_job.kind == fdtd_pkg::JOB_VSWEEP
                                || i_job.kind == fdtd_pkg::JOB_CSWEEP) begin
                            r_comp <= fdtd_pkg::COMP_X;
                            r_y    <= '0;
                            r_z    <= '0;
                        end else begin
                            r_comp <= i_job.comp;
                            r_y    <= i_job.y;
                            r_z    <= i_job.z;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_kind)
                        fdtd_pkg::JOB_READ: begin
                            r_state <= S_RDATA;
                        end
                        fdtd_pkg::JOB_VSWEEP, fdtd_pkg::JOB_CSWEEP: begin
                            r_k     <= '0;
                            r_state <= S_RD;
                        end
                        default: begin
                            r_res.read_data <= '0;
                            r_res.status    <= r_status;
                            r_res_valid     <= 1'b1;
                            r_state         <= S_IDLE;
                        end
                    endcase
                end
                S_RDATA: begin
                    r_res.read_data <= r_rdata[r_tgt];
                    r_res.status    <= r_status;
                    r_res_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_RD: begin
                    if (r_k == 3'd0) begin
                        r_curl <= '0;
                    end else begin
                        r_curl <= r_tneg ? r_curl - w_tval : r_curl + w_tval;
                    end
                    if (r_k == 3'd1) begin
                        r_own <= r_rdata[w_own_idx];
                        r_dec <= r_rdata[w_dec_idx];
                        r_cpl <= r_rdata[w_cpl_idx];
                    end
                    if (r_k == 3'd4) begin
                        r_state <= S_MUL0;
                    end else begin
                        r_tneg <= w_term.neg;
                        r_tzero <= w_term.zero;
                        r_k     <= r_k + 1'b1;
                    end
                end
                S_MUL0: begin
                    r_prod     <= w_prod;
                    r_curl_sat <= sat32(r_curl);
                    r_state    <= S_MUL1;
                end
                S_MUL1: begin
                    r_p0    <= round30(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_p1    <= round30(r_prod);
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_k     <= '0;
                    r_state <= S_RD;
                    if (r_comp != fdtd_pkg::COMP_Z) begin
                        r_comp <= r_comp + 1'b1;
                    end else begin
                        r_comp <= fdtd_pkg::COMP_X;
                        if (!w_last_z) begin
                            r_z <= r_z + 1'b1;
                        end else begin
                            r_z <= '0;
                            if (!w_last_y) begin
                                r_y <= r_y + 1'b1;
                            end else begin
                                r_y <= '0;
                                if (!w_last_x) begin
                                    r_x <= r_x + 1'b1;
                                end else begin
                                    r_res.read_data <= '0;
                                    r_res.status    <= r_status;
                                    r_res_valid     <= 1'b1;
                                    r_state         <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/fdtd_yee_field_update_top.sv
// Top level of the fixed-point FDTD Yee-grid field update block.
//
// This block holds a grid of up to 8 x 8 x 8 cells with three-component
// voltage and current fields in Q16.16 and per-word decay and coupling
// coefficients in Q2.30. Each command transaction writes or reads one word,
// or sweeps a slab of x planes with the voltage or the current update, and
// always returns exactly one result transaction with read data and status.
// After reset the block first runs a clearing pass over the 3 * 8 * 8 * 8 =
// 1536 words of the voltage and current stores while full stays high;
// configuration writes are accepted during that time. In a sweep the four
// neighbor reads of each field word go one at a time through the single
// read port of the neighbor field store, and the decay and coupling
// products share one 32 x 32 multiplier. A two-entry command queue lets new
// commands be pushed while the engine works or while a result waits to be
// popped. Grid sizes live in three 4-bit registers at byte addresses 0, 4
// and 8 and are used clamped to 2..8; they may only be changed while the
// block is idle.
module fdtd_yee_field_update_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fdtd_pkg::t_in_item  i_item,
    input  logic                push,
    output logic                full,
    output fdtd_pkg::t_out_item o_result,
    output logic                empty,
    input  logic                pop,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [3:0]      r_size_x;
    logic [3:0]      r_size_y;
    logic [3:0]      r_size_z;
    logic            w_cfg_write;
    fdtd_pkg::t_dims w_dims;
    fdtd_pkg::t_job  w_job;
    logic            w_job_valid;
    logic            w_job_take;
    logic            w_clearing;

    // Clamp a size register to the range that the grid supports.
    function automatic logic [fdtd_pkg::DIM_W-1:0] clamp_size(input logic [3:0] v,
                                                              input int mx);
        logic [fdtd_pkg::DIM_W-1:0] e;
        e = fdtd_pkg::DIM_W'(v);
        if (e < fdtd_pkg::DIM_W'(2)) begin
            return fdtd_pkg::DIM_W'(2);
        end else if (e > fdtd_pkg::DIM_W'(mx)) begin
            return fdtd_pkg::DIM_W'(mx);
        end
        return e;
    endfunction

    // The configuration port never inserts wait states.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= 4'd8;
            r_size_y <= 4'd8;
            r_size_z <= 4'd8;
        end else if (w_cfg_write) begin
            case (paddr[3:2])
                fdtd_pkg::REG_SIZE_X: r_size_x <= pwdata[3:0];
                fdtd_pkg::REG_SIZE_Y: r_size_y <= pwdata[3:0];
                fdtd_pkg::REG_SIZE_Z: r_size_z <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fdtd_pkg::REG_SIZE_X: prdata = 32'(r_size_x);
            fdtd_pkg::REG_SIZE_Y: prdata = 32'(r_size_y);
            fdtd_pkg::REG_SIZE_Z: prdata = 32'(r_size_z);
            default:              prdata = '0;
        endcase
    end

    // The clamped grid sizes are what both the front end and the engine see.
    assign w_dims.sx = clamp_size(r_size_x, fdtd_pkg::MAX_X);
    assign w_dims.sy = clamp_size(r_size_y, fdtd_pkg::MAX_Y);
    assign w_dims.sz = clamp_size(r_size_z, fdtd_pkg::MAX_Z);

    // The front end validates addresses, clips sweep ranges and queues jobs.
    fdtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_push      (push),
        .o_full      (full),
        .i_dims      (w_dims),
        .i_clearing  (w_clearing),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take)
    );

    // The engine owns the stores and produces one result per job.
    fdtd_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (w_dims),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .o_clearing  (w_clearing),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

### design/fdtd_chk.sv
// Port-level checker for the FDTD field update block, with its bind.
module fdtd_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                pop,
    input logic                empty,
    input fdtd_pkg::t_out_item o_result
);

    // Reset starts the clearing pass: no commands taken, no result pending.
    a_reset_state: assert property (@(posedge i_clk) !i_rst_n |=> full && empty)
        else $error("full or empty wrong after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.status != 2'd3)
        else $error("undefined status code on result");

    // Only successful reads carry data; every error result reads zero.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.status != fdtd_pkg::ST_OK |-> o_result.read_data == '0)
        else $error("nonzero read data with error status");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

endmodule

bind fdtd_yee_field_update_top fdtd_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
